>>> rtl/core/murmur2_hash_32_top_defines.svh
// Assertion macros for the hash core modules (used by mh2_ctrl).
`ifndef MURMUR2_HASH_32_TOP_DEFINES_SVH
`define MURMUR2_HASH_32_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define MH2_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mh2 assertion failed");
`define MH2_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mh2 reset assertion failed");
`else
`define MH2_ASSERT(lbl, clk, rst_n, prop)
`define MH2_ASSERT_NR(lbl, clk, prop)
`endif

`endif

>>> rtl/core/mh2_pkg.sv
package mh2_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int          WORD_SHIFT  = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;

    // register file: one 32-bit register at byte address 0
    localparam int          ADDR_W      = 3;
    localparam logic [0:0]  REG_SEED    = 1'b0;

    // operations of the shared multiplier
    localparam logic [2:0]  OP_NONE = 3'd0;
    localparam logic [2:0]  OP_K1   = 3'd1;  // k = k*M
    localparam logic [2:0]  OP_K2   = 3'd2;  // k = (k ^ k>>24)*M
    localparam logic [2:0]  OP_HW   = 3'd3;  // h = h*M ^ k
    localparam logic [2:0]  OP_HP   = 3'd4;  // h = (h ^ k)*M
    localparam logic [2:0]  OP_FIN  = 3'd5;  // h = (h ^ h>>13)*M

    typedef struct packed {
        logic       load;
        logic [2:0] mul_op;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic in_full;
        logic in_part;
        logic in_last;
        logic last;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/core/mh2_regs.sv
module mh2_regs
    import mh2_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [31:0]       o_seed
);

    logic [31:0] r_seed;
    logic        reg_hit;
    logic        wr_en;

    assign reg_hit = (paddr[ADDR_W-1:2] == REG_SEED);
    assign wr_en   = psel & penable & pwrite & reg_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (wr_en) begin
            r_seed <= pwdata;
        end
    end

    assign prdata = reg_hit ? r_seed : '0;
    assign pready = 1'b1;
    assign o_seed = r_seed;

endmodule

>>> rtl/core/mh2_dp.sv
module mh2_dp
    import mh2_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_seed,
    input  logic [31:0] i_key_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    input  logic [15:0] i_key_length,
    input  logic        i_ready,
    input  t_cmd        i_cmd,
    output t_stat       o_st,
    output logic        o_valid,
    output logic [31:0] o_hash_value
);

    logic [31:0] r_h;
    logic [31:0] r_k;
    logic        r_last;
    logic        r_first;
    logic [31:0] r_out;
    logic        r_out_valid;

    logic [31:0] key_mask;
    logic [31:0] mul_a;
    logic [31:0] mul_p;
    logic        out_free;

    always_comb begin
        unique case (i_byte_count)
            3'd1:    key_mask = 32'h0000_00ff;
            3'd2:    key_mask = 32'h0000_ffff;
            3'd3:    key_mask = 32'h00ff_ffff;
            default: key_mask = 32'hffff_ffff;
        endcase
    end

    // operand select for the single multiplier
    always_comb begin
        unique case (i_cmd.mul_op)
            OP_K1:   mul_a = r_k;
            OP_K2:   mul_a = r_k ^ (r_k >> WORD_SHIFT);
            OP_HW:   mul_a = r_h;
            OP_HP:   mul_a = r_h ^ r_k;
            OP_FIN:  mul_a = r_h ^ (r_h >> FIN_SHIFT_A);
            default: mul_a = r_h;
        endcase
    end

    assign mul_p    = mul_a * MIX_MUL;
    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h     <= '0;
            r_first <= 1'b1;
            r_last  <= 1'b0;
        end else if (i_cmd.load) begin
            if (r_first) begin
                r_h <= i_seed ^ {16'b0, i_key_length};
            end
            // the beat after a last beat opens a new key
            r_first <= i_last_word;
            r_last  <= i_last_word;
        end else begin
            unique case (i_cmd.mul_op)
                OP_HW:          r_h <= mul_p ^ r_k;
                OP_HP, OP_FIN:  r_h <= mul_p;
                default:        r_h <= r_h;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_k <= i_key_word & key_mask;
        end else if (i_cmd.mul_op == OP_K1 || i_cmd.mul_op == OP_K2) begin
            r_k <= mul_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_h ^ (r_h >> FIN_SHIFT_B);
        end
    end

    assign o_st.in_full  = (i_byte_count >= 3'd4);
    assign o_st.in_part  = (i_byte_count != 3'd0) && (i_byte_count < 3'd4);
    assign o_st.in_last  = i_last_word;
    assign o_st.last     = r_last;
    assign o_st.out_free = out_free;

    assign o_valid      = r_out_valid;
    assign o_hash_value = r_out;

endmodule

>>> rtl/core/mh2_ctrl.sv
`include "murmur2_hash_32_top_defines.svh"

module mh2_ctrl
    import mh2_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_stat i_st,
    output t_cmd  o_cmd,
    output logic  o_ready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_K1   = 3'd1;
    localparam logic [2:0] S_K2   = 3'd2;
    localparam logic [2:0] S_HW   = 3'd3;
    localparam logic [2:0] S_HP   = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_FOUT = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd.load     = 1'b0;
        o_cmd.mul_op   = OP_NONE;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    priority if (i_st.in_full) begin
                        n_state = S_K1;
                    end else if (i_st.in_part) begin
                        n_state = S_HP;
                    end else if (i_st.in_last) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_K1: begin
                o_cmd.mul_op = OP_K1;
                n_state      = S_K2;
            end
            S_K2: begin
                o_cmd.mul_op = OP_K2;
                n_state      = S_HW;
            end
            S_HW: begin
                o_cmd.mul_op = OP_HW;
                n_state      = i_st.last ? S_FIN : S_IDLE;
            end
            S_HP: begin
                o_cmd.mul_op = OP_HP;
                n_state      = i_st.last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                o_cmd.mul_op = OP_FIN;
                n_state      = S_FOUT;
            end
            S_FOUT: begin
                // hold the finished hash until the output register frees up
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    `MH2_ASSERT_NR(a_reset_idle, i_clk, !i_rst_n |=> r_state == S_IDLE)
    `MH2_ASSERT(a_k1_to_k2, i_clk, i_rst_n, r_state == S_K1 |=> r_state == S_K2)
    `MH2_ASSERT(a_hw_exit, i_clk, i_rst_n,
        r_state == S_HW |=> (r_state == S_IDLE || r_state == S_FIN))
    `MH2_ASSERT(a_fout_hold, i_clk, i_rst_n,
        (r_state == S_FOUT && !i_st.out_free) |=> r_state == S_FOUT)

endmodule

>>> rtl/core/murmur2_hash_32_top.sv
// 32-bit MurmurHash2 engine, keys streamed one little-endian word per beat.
// Input channel: i_valid / o_ready with i_key_word, i_byte_count (4 on all
// but the last beat, 0 only for an empty key), i_last_word and i_key_length
// (sampled on the first beat of a key). Output channel: o_valid / i_ready
// with o_hash_value, one beat per key, after the beat marked last.
// Seed register at APB byte address 0; it is picked up at the start of
// the next key. pready is tied high.
// Steps: a full word is accepted, then takes three multiplies on the one
// shared 32x32 multiplier; a partial word is accepted, then mixed into
// the hash on the multiplier; an empty, non-last word is only accepted.
// The last beat adds the final mix and the output load.
// One word is in flight at a time; o_ready is high only when idle.
// A finished hash sits in the output register while the next key is
// accepted; if it is still unread when the next hash is done, the core
// waits until i_ready frees the register.
// Reset clears the seed, the running hash and the output valid.
module murmur2_hash_32_top
    import mh2_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [31:0]       i_key_word,
    input  logic [2:0]        i_byte_count,
    input  logic              i_last_word,
    input  logic [15:0]       i_key_length,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_hash_value,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [31:0] seed;
    t_cmd        cmd;
    t_stat       st;

    mh2_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_seed  (seed)
    );

    mh2_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_st    (st),
        .o_cmd   (cmd),
        .o_ready (o_ready)
    );

    mh2_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed       (seed),
        .i_key_word   (i_key_word),
        .i_byte_count (i_byte_count),
        .i_last_word  (i_last_word),
        .i_key_length (i_key_length),
        .i_ready      (i_ready),
        .i_cmd        (cmd),
        .o_st         (st),
        .o_valid      (o_valid),
        .o_hash_value (o_hash_value)
    );

endmodule
